// ===== hw/rtl/lfrng_pkg.sv =====
// ----------------------------------------------------------------------------
// lfrng_pkg
// Shared types and constants of the seeded lagged Fibonacci word generator.
// ----------------------------------------------------------------------------
package lfrng_pkg;

   // word and counter widths
   localparam int WORD_W   = 31;
   localparam int COUNT_W  = 21;
   localparam int MULT_W   = 15;
   localparam int PROD_W   = WORD_W + MULT_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [MULT_W-1:0]  LCG_MULT  = 15'd16807;
   localparam logic [WORD_W:0]    LCG_MOD   = 32'h7FFF_FFFF;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_LENGTH = 1'd1;

   localparam logic [WORD_W-1:0]  SEED_RESET       = 31'd1;
   localparam logic [COUNT_W-1:0] RUN_LENGTH_RESET = 21'd100000;

   // how a word is formed
   localparam logic [1:0] MODE_SEED = 2'd0;
   localparam logic [1:0] MODE_LCG  = 2'd1;
   localparam logic [1:0] MODE_FIB  = 2'd2;

   // per-item control handed from the issue stage to the datapath
   typedef struct packed {
      logic [1:0] mode;
      logic       last;
      logic       fwd_near;
   } step_ctl_type;

endpackage

// ===== hw/rtl/lfrng_ring.sv =====
// ----------------------------------------------------------------------------
// lfrng_ring
// History ring: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lfrng_ring #(
   parameter int DEPTH  = 17,
   parameter int ADDR_W = 5
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_far_addr,
   input  logic [ADDR_W-1:0]             rd_near_addr,
   output logic [lfrng_pkg::WORD_W-1:0]  rd_far_data,
   output logic [lfrng_pkg::WORD_W-1:0]  rd_near_data,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [lfrng_pkg::WORD_W-1:0]  wr_data
);
   import lfrng_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_far_ff;
   logic [WORD_W-1:0] rd_near_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports, old data on a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_far_ff  <= mem[rd_far_addr];
         rd_near_ff <= mem[rd_near_addr];
      end
   end

   assign rd_far_data  = rd_far_ff;
   assign rd_near_data = rd_near_ff;

endmodule

// ===== hw/rtl/lfrng_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfrng_ctrl
// Issue stage: config registers, run counter, ring pointer, read addresses
// and the per-item control word.
// ----------------------------------------------------------------------------
module lfrng_ctrl #(
   parameter int LONG_LAG  = 17,
   parameter int SHORT_LAG = 5,
   parameter int ADDR_W    = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_write,
   input  logic [lfrng_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lfrng_pkg::CSR_DATA_W-1:0]  csr_data,
   // accepted item
   input  logic                              accept,
   input  logic                              restart,
   // write of the item now leaving the datapath
   input  logic                              wr_en,
   input  logic [ADDR_W-1:0]                 wr_addr,
   // issue outputs
   output logic [ADDR_W-1:0]                 far_addr,
   output logic [ADDR_W-1:0]                 near_addr,
   output logic [ADDR_W-1:0]                 slot_addr,
   output lfrng_pkg::step_ctl_type           step_ctl,
   output logic [lfrng_pkg::WORD_W-1:0]      seed
);
   import lfrng_pkg::*;

   localparam int NEAR_BACK = SHORT_LAG % LONG_LAG;

   logic [WORD_W-1:0]  seed_ff,       seed_in;
   logic [COUNT_W-1:0] run_length_ff, run_length_in;
   logic [COUNT_W-1:0] count_ff,      count_in;
   logic [ADDR_W-1:0]  ptr_ff,        ptr_in;

   logic               start;
   logic [COUNT_W-1:0] old_count;
   logic [ADDR_W-1:0]  ptr_use;
   logic [ADDR_W:0]    near_sum;

   // configuration registers
   always_comb begin
      seed_in       = seed_ff;
      run_length_in = run_length_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SEED:       seed_in       = csr_data[WORD_W-1:0];
            CSR_RUN_LENGTH: run_length_in = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // a run starts on restart or on the very first item
   assign start     = restart || (count_ff == '0);
   assign old_count = start ? '0 : count_ff;
   assign ptr_use   = start ? '0 : ptr_ff;

   // short-lag slot, wrapped inside the ring
   always_comb begin
      near_sum = {1'b0, ptr_use} + (ADDR_W+1)'(LONG_LAG - NEAR_BACK);
      if (near_sum >= (ADDR_W+1)'(LONG_LAG)) begin
         near_sum = near_sum - (ADDR_W+1)'(LONG_LAG);
      end
   end

   assign far_addr  = ptr_use;
   assign near_addr = near_sum[ADDR_W-1:0];
   assign slot_addr = ptr_use;
   assign seed      = seed_ff;

   // control word of the accepted item
   always_comb begin
      if (start) begin
         step_ctl.mode = MODE_SEED;
      end else if (count_ff <= COUNT_W'(LONG_LAG)) begin
         step_ctl.mode = MODE_LCG;
      end else begin
         step_ctl.mode = MODE_FIB;
      end
      step_ctl.last     = (old_count != COUNT_MAX) &&
                          ((old_count + COUNT_W'(1)) == run_length_ff);
      // slot being written this very edge: take the word from the datapath
      step_ctl.fwd_near = wr_en && (wr_addr == near_addr);
   end

   // pointer and counter advance
   always_comb begin
      ptr_in   = ptr_ff;
      count_in = count_ff;
      if (accept) begin
         ptr_in   = (ptr_use == ADDR_W'(LONG_LAG - 1)) ? '0 : ptr_use + ADDR_W'(1);
         count_in = (old_count == COUNT_MAX) ? COUNT_MAX : old_count + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= SEED_RESET;
         run_length_ff <= RUN_LENGTH_RESET;
         count_ff      <= '0;
         ptr_ff        <= '0;
      end else begin
         seed_ff       <= seed_in;
         run_length_ff <= run_length_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
      end
   end

endmodule

// ===== hw/rtl/lfrng_datapath.sv =====
// ----------------------------------------------------------------------------
// lfrng_datapath
// Compute stage and output register: seed, multiplicative step with the
// Mersenne fold, or lagged add; ring write-back and result handshake.
// ----------------------------------------------------------------------------
module lfrng_datapath #(
   parameter int ADDR_W = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   // issue side
   input  logic                             accept,
   output logic                             issue_ready,
   input  lfrng_pkg::step_ctl_type          step_ctl,
   input  logic [ADDR_W-1:0]                slot_addr,
   input  logic [lfrng_pkg::WORD_W-1:0]     seed,
   // ring
   input  logic [lfrng_pkg::WORD_W-1:0]     rd_far_data,
   input  logic [lfrng_pkg::WORD_W-1:0]     rd_near_data,
   output logic                             wr_en,
   output logic [ADDR_W-1:0]                wr_addr,
   output logic [lfrng_pkg::WORD_W-1:0]     wr_data,
   // result
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [lfrng_pkg::WORD_W-1:0]     out_value,
   output logic                             out_last
);
   import lfrng_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   step_ctl_type          s1_ctl_ff;
   logic [ADDR_W-1:0]     s1_addr_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]     out_value_ff;
   logic                  out_last_ff;
   logic [WORD_W-1:0]     prev_word_ff;

   logic                  s1_adv;
   logic [PROD_W-1:0]     prod;
   logic [WORD_W:0]       fold;
   logic [WORD_W-1:0]     lcg_word;
   logic [WORD_W-1:0]     near_word;
   logic [WORD_W-1:0]     word;

   // stage moves on when the output register is free or being emptied
   assign s1_adv      = s1_valid_ff && (!out_valid_ff || out_ready);
   assign issue_ready = !s1_valid_ff || s1_adv;

   // x * 16807 mod (2^31 - 1): fold high part onto low, one correction
   assign prod = PROD_W'(prev_word_ff) * PROD_W'(LCG_MULT);
   assign fold = {1'b0, prod[WORD_W-1:0]} + (WORD_W+1)'(prod[PROD_W-1:WORD_W]);
   always_comb begin
      if (fold >= LCG_MOD) begin
         lcg_word = WORD_W'(fold - LCG_MOD);
      end else begin
         lcg_word = fold[WORD_W-1:0];
      end
   end

   // lagged add, short-lag word forwarded when written on the issue edge
   assign near_word = s1_ctl_ff.fwd_near ? prev_word_ff : rd_near_data;

   always_comb begin
      unique case (s1_ctl_ff.mode)
         MODE_SEED: word = seed;
         MODE_LCG:  word = lcg_word;
         MODE_FIB:  word = rd_far_data + near_word;
         default:   word = seed;
      endcase
   end

   assign wr_en   = s1_adv;
   assign wr_addr = s1_addr_ff;
   assign wr_data = word;

   // handshake state
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff  <= step_ctl;
         s1_addr_ff <= slot_addr;
      end
      if (s1_adv) begin
         out_value_ff <= word;
         out_last_ff  <= s1_ctl_ff.last;
         prev_word_ff <= word;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

endmodule

// ===== hw/rtl/lcg_seeded_lagged_fibonacci_rng.sv =====
// ----------------------------------------------------------------------------
// lcg_seeded_lagged_fibonacci_rng
// Seeded additive lagged Fibonacci generator producing 31-bit words.
// ----------------------------------------------------------------------------
// Each request item yields one 31-bit word, read as an unsigned Q0.31
// fraction. A run opens with the seed (on restart, and on the first item
// after reset), continues with LONG_LAG words of the x*16807 mod (2^31-1)
// generator and then follows x[n] = x[n-LONG_LAG] + x[n-SHORT_LAG] mod 2^31.
// The run_length-th word of a run carries tlast; the generator runs on past
// it and tlast stays low until the next restart. Throughput is one item per
// clock while rsp_tready is high; items pass the compute register and then
// the output register. The rate is set by the history ring, read at two
// addresses in the issue cycle and written back in the compute cycle, with
// the short-lag word forwarded when it is being written. No clearing pass after reset.
// ----------------------------------------------------------------------------
module lcg_seeded_lagged_fibonacci_rng #(
   parameter int LONG_LAG  = 17,
   parameter int SHORT_LAG = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   // request items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [0] restart, [7:1] zero
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // [30:0] value, [31] zero
   output logic                              rsp_tlast,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfrng_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lfrng_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lfrng_pkg::*;

   localparam int ADDR_W = $clog2(LONG_LAG);

   logic               accept;
   logic               issue_ready;
   logic [ADDR_W-1:0]  far_addr;
   logic [ADDR_W-1:0]  near_addr;
   logic [ADDR_W-1:0]  slot_addr;
   step_ctl_type       step_ctl;
   logic [WORD_W-1:0]  seed;
   logic [WORD_W-1:0]  rd_far_data;
   logic [WORD_W-1:0]  rd_near_data;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [WORD_W-1:0]  out_value;

   assign csr_ready  = 1'b1;
   assign req_tready = issue_ready;
   assign accept     = req_tvalid && issue_ready;

   lfrng_ctrl #(
      .LONG_LAG  (LONG_LAG),
      .SHORT_LAG (SHORT_LAG),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .restart   (req_tdata[0]),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .far_addr  (far_addr),
      .near_addr (near_addr),
      .slot_addr (slot_addr),
      .step_ctl  (step_ctl),
      .seed      (seed)
   );

   lfrng_ring #(
      .DEPTH  (LONG_LAG),
      .ADDR_W (ADDR_W)
   ) u_ring (
      .clock        (clock),
      .rd_en        (accept),
      .rd_far_addr  (far_addr),
      .rd_near_addr (near_addr),
      .rd_far_data  (rd_far_data),
      .rd_near_data (rd_near_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   lfrng_datapath #(
      .ADDR_W (ADDR_W)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .issue_ready  (issue_ready),
      .step_ctl     (step_ctl),
      .slot_addr    (slot_addr),
      .seed         (seed),
      .rd_far_data  (rd_far_data),
      .rd_near_data (rd_near_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_value    (out_value),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_value};

endmodule
